@@ src/kwdt_pkg.sv @@
package kwdt_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // register select
  localparam logic SEL_COUNT = 1'b0;
  localparam logic SEL_CTRL  = 1'b1;

  // write keys
  localparam logic [7:0] KEY_COUNT = 8'h5a;
  localparam logic [7:0] KEY_CTRL  = 8'ha5;

  // control/status bit positions
  localparam int unsigned BIT_ENABLE   = 7;
  localparam int unsigned BIT_WATCHDOG = 6;
  localparam int unsigned BIT_RSTSEL   = 5;
  localparam int unsigned BIT_WOVF     = 4;
  localparam int unsigned BIT_IOVF     = 3;

  localparam logic [7:0] FLAG_MASK = 8'h18;

  localparam int unsigned PRESCALE_W = 12;
  localparam int unsigned EXPO_W     = 4;
  localparam logic [EXPO_W-1:0] EXPO_MAX = 4'd12;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        reg_sel;
    logic [15:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       write_ignored;
    logic       interval_irq;
    logic       reset_request;
    logic       reset_kind;
  } res_t;

endpackage

@@ src/kwdt_core.sv @@
module kwdt_core import kwdt_pkg::*; #(
  parameter int unsigned BaseDivLog2 = 5
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  output res_t res_o
);

  logic [7:0]            count_q, count_d;
  logic [PRESCALE_W-1:0] presc_q, presc_d;
  logic [7:0]            ctrl_q, ctrl_d;

  logic [EXPO_W-1:0]     expo_raw;
  logic [EXPO_W-1:0]     expo;
  logic [PRESCALE_W:0]   period;
  logic [PRESCALE_W-1:0] presc_inc;
  logic [7:0]            count_inc;
  logic [7:0]            wr_key;
  logic [7:0]            wr_val;
  logic                  step;
  logic                  pulse;

  assign wr_key    = req_i.write_data[15:8];
  assign wr_val    = req_i.write_data[7:0];
  assign expo_raw  = EXPO_W'(BaseDivLog2) + {1'b0, ctrl_q[2:0]};
  assign expo      = (expo_raw > EXPO_MAX) ? EXPO_MAX : expo_raw;
  assign period    = (PRESCALE_W+1)'(1) << expo;
  assign presc_inc = presc_q + 1'b1;
  assign step      = (presc_inc == '0) || ({1'b0, presc_inc} >= period);
  assign count_inc = count_q + 8'd1;

  always_comb begin
    count_d = count_q;
    presc_d = presc_q;
    ctrl_d  = ctrl_q;
    pulse   = 1'b0;
    res_o.read_data     = '0;
    res_o.write_ignored = 1'b0;
    case (req_i.req_type)
      REQ_TICK: begin
        if (ctrl_q[BIT_ENABLE]) begin
          if (step) begin
            presc_d = '0;
            count_d = count_inc;
            if (count_inc == 8'd0) begin
              if (ctrl_q[BIT_WATCHDOG]) begin
                ctrl_d[BIT_WOVF] = 1'b1;
                pulse = 1'b1;
              end else begin
                ctrl_d[BIT_IOVF] = 1'b1;
              end
            end
          end else begin
            presc_d = presc_inc;
          end
        end
      end
      REQ_READ: begin
        res_o.read_data = (req_i.reg_sel == SEL_CTRL) ? ctrl_q : count_q;
      end
      REQ_WRITE: begin
        if (req_i.reg_sel == SEL_COUNT) begin
          if (wr_key == KEY_COUNT) begin
            count_d = wr_val;
          end else begin
            res_o.write_ignored = 1'b1;
          end
        end else begin
          if (wr_key == KEY_CTRL) begin
            // flags clear on 0, hold on 1
            ctrl_d = (wr_val & ~FLAG_MASK) | (ctrl_q & wr_val & FLAG_MASK);
          end else begin
            res_o.write_ignored = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_o.reset_request = pulse;
    res_o.interval_irq  = ctrl_d[BIT_IOVF] && !ctrl_d[BIT_WATCHDOG];
    res_o.reset_kind    = ctrl_d[BIT_RSTSEL];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      presc_q <= '0;
      ctrl_q  <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
      presc_q <= presc_d;
      ctrl_q  <= ctrl_d;
    end
  end

  // reset request only from a watchdog-mode wrap
  a_pulse_wdog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.reset_request |-> (ctrl_q[BIT_WATCHDOG] && count_q == 8'hff))
    else $error("reset request outside watchdog wrap");

  // overflow flag only rises on a tick transfer
  a_wovf_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ctrl_q[BIT_WOVF]) |-> $past(fire_i && req_i.req_type == REQ_TICK))
    else $error("watchdog flag set without a tick");

  // counter holds while no item is applied
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> ($stable(count_q) && $stable(ctrl_q) && $stable(presc_q)))
    else $error("state changed without a transfer");

endmodule

@@ src/keyed_watchdog_interval_timer_unit.sv @@
// keyed watchdog / interval timer, one request per transfer
//
// input channel: in_valid_i / in_stall_o with req_type_i, reg_sel_i,
// write_data_i; a transfer happens at an edge with valid high and stall low
// output channel: out_valid_o / out_stall_i, one result per request
// request 0 advances the prescaler while enabled, 1 reads a register, 2 writes a keyed
// register (0x5a for the counter, 0xa5 for control/status)
// path: the request lands in the input register; when the output register
// is free it is applied to the timer state and its result is loaded into
// the output register, which drives out_valid_o
// throughput: one request per cycle while the output is not held by out_stall_i,
// set by the single update between the input register and the output register
// a result waiting under out_stall_i does not block the input register; input
// stalls only when both the input and output registers are full and held
// reset: all timer state zero (timer stopped), both registers empty
module keyed_watchdog_interval_timer_unit import kwdt_pkg::*; #(
  parameter int unsigned BASE_DIVIDER_LOG2 = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic        reg_sel_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        write_ignored_o,
  output logic        interval_irq_o,
  output logic        reset_request_o,
  output logic        reset_kind_o
);

  // input register
  logic in_vld_q;
  req_t in_req_q;

  // output register
  logic out_vld_q;
  res_t out_res_q;

  logic out_free;  // output register can take a new result
  logic fire;      // request in input register is applied this cycle
  logic in_take;   // input transfer
  res_t core_res;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take || fire) begin
      in_vld_q <= in_take;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= '{req_type: req_type_i, reg_sel: reg_sel_i, write_data: write_data_i};
    end
  end

  // timer state and per-request update
  kwdt_core #(
    .BaseDivLog2(BASE_DIVIDER_LOG2)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (in_req_q),
    .res_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign read_data_o     = out_res_q.read_data;
  assign write_ignored_o = out_res_q.write_ignored;
  assign interval_irq_o  = out_res_q.interval_irq;
  assign reset_request_o = out_res_q.reset_request;
  assign reset_kind_o    = out_res_q.reset_kind;

  // an applied request always shows up as a result next cycle
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("applied request produced no result");

  // a held result blocks the apply step
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !fire)
    else $error("result overwritten while stalled");

endmodule
